@@ rtl/core/ethp_pkg.sv @@
package ethp_pkg;

  // Byte offsets within the frame and within each header
  localparam logic [15:0] EthHdrLen   = 16'd14;
  localparam logic [15:0] MacBytes    = 16'd6;
  localparam logic [15:0] IpOffTotLen = 16'd2;
  localparam logic [15:0] IpOffProto  = 16'd9;
  localparam logic [15:0] IpOffSrc    = 16'd12;
  localparam logic [15:0] IpOffDst    = 16'd16;
  localparam logic [15:0] IpAddrBytes = 16'd4;
  localparam logic [15:0] TcpOffSport = 16'd0;
  localparam logic [15:0] TcpOffDport = 16'd2;
  localparam logic [15:0] TcpOffDoff  = 16'd12;
  localparam logic [15:0] IdxMax      = 16'hFFFF;

  // Bits of the fixed header fields in the result word, payload head excluded
  localparam int unsigned HdrFieldBits = 244;

  typedef struct packed {
    logic [15:0] total_len;
    logic [5:0]  tcp_len;
    logic [15:0] tcp_dport;
    logic [15:0] tcp_sport;
    logic [31:0] dest_ip;
    logic [31:0] src_ip;
    logic [7:0]  protocol;
    logic [5:0]  ip_len;
    logic [15:0] ether_type;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
  } hdr_fields_t;

  typedef struct packed {
    logic valid;
    logic last;
  } in_ctrl_t;

endpackage

@@ rtl/core/ethp_in_stage.sv @@
module ethp_in_stage
  import ethp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  logic       take_i,
  output in_ctrl_t   ctrl_o,
  output logic [7:0] byte_o
);

  in_ctrl_t   ctrl_q, ctrl_d;
  logic [7:0] byte_q;

  assign ready_o = !ctrl_q.valid || take_i;

  always_comb begin
    ctrl_d = ctrl_q;
    if (ready_o) begin
      ctrl_d.valid = valid_i;
      ctrl_d.last  = last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      byte_q <= byte_i;
    end
  end

  assign ctrl_o = ctrl_q;
  assign byte_o = byte_q;

endmodule

@@ rtl/core/ethp_capture.sv @@
module ethp_capture
  import ethp_pkg::*;
#(
  parameter int unsigned PAYLOAD_HEAD_BYTES = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            fire_i,
  input  logic                            last_i,
  input  logic [7:0]                      byte_i,
  output hdr_fields_t                     fields_o,
  output logic [PAYLOAD_HEAD_BYTES*8-1:0] head_o
);

  localparam logic [15:0] HeadBytes = 16'(PAYLOAD_HEAD_BYTES);

  hdr_fields_t                     fields_q, fields_d;
  logic [PAYLOAD_HEAD_BYTES*8-1:0] head_q, head_d;
  logic [15:0]                     idx_q, idx_d;

  logic [5:0]  ip_len_cur;
  logic [5:0]  tcp_len_cur;
  logic [15:0] tcp_start;
  logic [15:0] pay_start;
  logic [15:0] pay_off;
  logic        pay_cap;

  // Header length written by this very byte takes effect at once
  assign ip_len_cur  = (fire_i && idx_q == EthHdrLen) ? {byte_i[3:0], 2'b00}
                                                       : fields_q.ip_len;
  assign tcp_start   = EthHdrLen + {10'd0, ip_len_cur};
  assign tcp_len_cur = (fire_i && idx_q == tcp_start + TcpOffDoff) ?
                       {byte_i[7:4], 2'b00} : fields_q.tcp_len;
  assign pay_start   = tcp_start + {10'd0, tcp_len_cur};
  assign pay_off     = idx_q - pay_start;
  // Payload is known only after the data offset byte went by
  assign pay_cap     = fire_i && (idx_q > tcp_start + TcpOffDoff) &&
                       (idx_q >= pay_start) && (pay_off < HeadBytes);

  always_comb begin
    fields_d         = fields_q;
    head_d           = head_q;
    idx_d            = idx_q;
    fields_d.ip_len  = ip_len_cur;
    fields_d.tcp_len = tcp_len_cur;
    if (fire_i) begin
      if (idx_q < MacBytes) begin
        fields_d.dst_mac = {fields_q.dst_mac[39:0], byte_i};
      end else if (idx_q < 16'd2 * MacBytes) begin
        fields_d.src_mac = {fields_q.src_mac[39:0], byte_i};
      end else if (idx_q < EthHdrLen) begin
        fields_d.ether_type = {fields_q.ether_type[7:0], byte_i};
      end
      if (idx_q == EthHdrLen + IpOffTotLen || idx_q == EthHdrLen + IpOffTotLen + 16'd1) begin
        fields_d.total_len = {fields_q.total_len[7:0], byte_i};
      end
      if (idx_q == EthHdrLen + IpOffProto) begin
        fields_d.protocol = byte_i;
      end
      if (idx_q >= EthHdrLen + IpOffSrc && idx_q < EthHdrLen + IpOffSrc + IpAddrBytes) begin
        fields_d.src_ip = {fields_q.src_ip[23:0], byte_i};
      end
      if (idx_q >= EthHdrLen + IpOffDst && idx_q < EthHdrLen + IpOffDst + IpAddrBytes) begin
        fields_d.dest_ip = {fields_q.dest_ip[23:0], byte_i};
      end
      if (idx_q == tcp_start + TcpOffSport || idx_q == tcp_start + TcpOffSport + 16'd1) begin
        fields_d.tcp_sport = {fields_q.tcp_sport[7:0], byte_i};
      end
      if (idx_q == tcp_start + TcpOffDport || idx_q == tcp_start + TcpOffDport + 16'd1) begin
        fields_d.tcp_dport = {fields_q.tcp_dport[7:0], byte_i};
      end
      // First payload byte lands in the top lane
      for (int j = 0; j < PAYLOAD_HEAD_BYTES; j++) begin
        if (pay_cap && pay_off == HeadBytes - 16'd1 - 16'(j)) begin
          head_d[j*8 +: 8] = head_q[j*8 +: 8] | byte_i;
        end
      end
      if (idx_q != IdxMax) begin
        idx_d = idx_q + 16'd1;
      end
    end
  end

  // Clear everything once the frame's last byte is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fields_q <= '0;
      head_q   <= '0;
      idx_q    <= '0;
    end else if (fire_i && last_i) begin
      fields_q <= '0;
      head_q   <= '0;
      idx_q    <= '0;
    end else begin
      fields_q <= fields_d;
      head_q   <= head_d;
      idx_q    <= idx_d;
    end
  end

  assign fields_o = fields_d;
  assign head_o   = head_d;

endmodule

@@ rtl/core/ethp_out_stage.sv @@
module ethp_out_stage
  import ethp_pkg::*;
#(
  parameter int unsigned PAYLOAD_HEAD_BYTES = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  hdr_fields_t                     fields_i,
  input  logic [PAYLOAD_HEAD_BYTES*8-1:0] head_i,
  output logic                            free_o,
  output logic                            valid_o,
  input  logic                            ready_i,
  output hdr_fields_t                     fields_o,
  output logic [15:0]                     plen_o,
  output logic [PAYLOAD_HEAD_BYTES*8-1:0] head_o
);

  localparam logic [15:0] HeadBytes = 16'(PAYLOAD_HEAD_BYTES);

  logic                            valid_q;
  hdr_fields_t                     fields_q;
  logic [15:0]                     plen_q, plen_d;
  logic [PAYLOAD_HEAD_BYTES*8-1:0] head_q, head_d;
  logic [15:0]                     hdr_sum;

  assign free_o  = !valid_q || ready_i;
  assign hdr_sum = {10'd0, fields_i.ip_len} + {10'd0, fields_i.tcp_len};
  assign plen_d  = (fields_i.total_len > hdr_sum) ? fields_i.total_len - hdr_sum : 16'd0;

  // Keep lane j only if the payload reaches that far
  always_comb begin
    head_d = '0;
    for (int j = 0; j < PAYLOAD_HEAD_BYTES; j++) begin
      if (plen_d > HeadBytes - 16'd1 - 16'(j)) begin
        head_d[j*8 +: 8] = head_i[j*8 +: 8];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      fields_q <= fields_i;
      plen_q   <= plen_d;
      head_q   <= head_d;
    end
  end

  assign valid_o  = valid_q;
  assign fields_o = fields_q;
  assign plen_o   = plen_q;
  assign head_o   = head_q;

endmodule

@@ rtl/core/eth_ipv4_tcp_header_parser.sv @@
// Ethernet / IPv4 / TCP header parser.
// Input channel (s_axis): one frame byte per item in wire order, tlast on the
// final byte of the frame. Output channel (m_axis): one item per frame, sent
// after the last byte, carrying the MAC addresses, EtherType, IPv4 header
// length, protocol, addresses, TCP ports, TCP header length, payload length
// and the first PAYLOAD_HEAD_BYTES payload bytes (zero filled).
// Structure: input register -> capture stage (header field registers, byte
// counter) -> result register. The capture stage updates one field set per
// byte; the result register computes payload length and masks the head.
// Throughput: one byte per cycle while no last byte is held for the result
// register. The result register loads a frame's result when its last byte
// leaves the input register through the capture stage.
// Reset: all field registers and the byte counter clear, both channels empty.
// Stall: while a result waits on m_axis, non-last bytes of the next frame keep
// flowing; a last byte is held in the input register until the result
// register frees, and s_axis_tready_o drops only while such a byte is held.
module eth_ipv4_tcp_header_parser
  import ethp_pkg::*;
#(
  parameter int unsigned PAYLOAD_HEAD_BYTES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,  // data_byte
  input  logic                s_axis_tlast_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // dst_mac, src_mac, ether_type, ip_header_len, ip_protocol, src_ip,
  // dest_ip, tcp_sport, tcp_dport, tcp_header_len, payload_len, payload_head
  output logic [((HdrFieldBits + 8*PAYLOAD_HEAD_BYTES + 7) / 8) * 8 - 1:0] m_axis_tdata_o
);

  localparam int unsigned DataW = ((HdrFieldBits + 8*PAYLOAD_HEAD_BYTES + 7) / 8) * 8;
  localparam int unsigned HeadW = PAYLOAD_HEAD_BYTES * 8;

  in_ctrl_t    in_ctrl;
  logic [7:0]  in_byte;
  logic        cap_fire;
  logic        out_free;
  hdr_fields_t cap_fields;
  logic [HeadW-1:0] cap_head;
  hdr_fields_t out_fields;
  logic [15:0] out_plen;
  logic [HeadW-1:0] out_head;

  // Hold a last byte until the result register can take its frame's result
  assign cap_fire = in_ctrl.valid && (!in_ctrl.last || out_free);

  ethp_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .byte_i  (s_axis_tdata_i),
    .last_i  (s_axis_tlast_i),
    .take_i  (cap_fire),
    .ctrl_o  (in_ctrl),
    .byte_o  (in_byte)
  );

  ethp_capture #(
    .PAYLOAD_HEAD_BYTES(PAYLOAD_HEAD_BYTES)
  ) u_capture (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (cap_fire),
    .last_i   (in_ctrl.last),
    .byte_i   (in_byte),
    .fields_o (cap_fields),
    .head_o   (cap_head)
  );

  ethp_out_stage #(
    .PAYLOAD_HEAD_BYTES(PAYLOAD_HEAD_BYTES)
  ) u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (cap_fire && in_ctrl.last),
    .fields_i (cap_fields),
    .head_i   (cap_head),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .fields_o (out_fields),
    .plen_o   (out_plen),
    .head_o   (out_head)
  );

  // Pack fields from the lowest bit up; zero pad to whole bytes
  assign m_axis_tdata_o = DataW'({out_head, out_plen, out_fields.tcp_len,
                                  out_fields.tcp_dport, out_fields.tcp_sport,
                                  out_fields.dest_ip, out_fields.src_ip,
                                  out_fields.protocol, out_fields.ip_len,
                                  out_fields.ether_type, out_fields.src_mac,
                                  out_fields.dst_mac});

  // A new result appears only after a last byte went through capture
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(cap_fire && in_ctrl.last))
    else $error("result without a captured last byte");

  // Input backpressure only comes from a held last byte behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_ctrl.valid && in_ctrl.last && m_axis_tvalid_o &&
                          !m_axis_tready_i))
    else $error("input stalled without a waiting result");

  // An empty payload carries no head bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_plen == 16'd0) |-> (out_head == '0))
    else $error("payload head not cleared for empty payload");

  // Header lengths are whole words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_fields.ip_len[1:0] == 2'b00 &&
                         out_fields.tcp_len[1:0] == 2'b00))
    else $error("header length not a multiple of four");

endmodule
